>>> hw/rtl/ctt_pkg.sv
// ============================================================================
// ctt_pkg
// Shared types and constants for the cosine taper truncation pipeline.
// ============================================================================
package ctt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q30       = 30;
    localparam int POS_W     = 24;
    localparam int VAL_W     = 32;
    localparam int F_W       = FRAC_BITS + 1;
    localparam int HSTEPS    = 5;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;

    // Horner divisors and their 2^32 reciprocals, innermost first
    localparam logic [6:0]  HORNER_DIV [0:HSTEPS-1] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [31:0] HORNER_RECIP [0:HSTEPS-1] = '{
        32'(64'd4294967296 / 90),
        32'(64'd4294967296 / 56),
        32'(64'd4294967296 / 30),
        32'(64'd4294967296 / 12),
        32'(64'd4294967296 / 2)
    };

    localparam logic REG_R_MIN = 1'b0;
    localparam logic REG_R_MAX = 1'b1;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_ZERO,
        MODE_TAPER
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic              flip;
        logic [VAL_W-1:0]  raw;
    } side_t;

endpackage

>>> hw/rtl/ctt_div.sv
// ============================================================================
// ctt_div
// Pipelined restoring divider: quotient = floor(off * 2^30 / d), off < d.
// ============================================================================
module ctt_div
    import ctt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [POS_W-1:0]     off,
    input  logic [POS_W-1:0]     d,
    input  side_t                in_side,
    output logic                 out_valid,
    output logic [Q30-1:0]       quo,
    output side_t                out_side
);

    logic              v_reg   [0:Q30-1];
    logic [POS_W-1:0]  rem_reg [0:Q30-1];
    logic [POS_W-1:0]  d_reg   [0:Q30-1];
    logic [Q30-1:0]    q_reg   [0:Q30-1];
    side_t             s_reg   [0:Q30-1];

    for (genvar i = 0; i < Q30; i++)
    begin : g_stage
        logic              v_prev;
        logic [POS_W-1:0]  r_prev;
        logic [POS_W-1:0]  d_prev;
        logic [Q30-1:0]    q_prev;
        side_t             s_prev;
        logic [POS_W:0]    dbl;
        logic              ge;
        logic [POS_W-1:0]  rem_next;

        if (i == 0)
        begin : g_first
            assign v_prev = in_valid;
            assign r_prev = off;
            assign d_prev = d;
            assign q_prev = '0;
            assign s_prev = in_side;
        end
        else
        begin : g_rest
            assign v_prev = v_reg[i-1];
            assign r_prev = rem_reg[i-1];
            assign d_prev = d_reg[i-1];
            assign q_prev = q_reg[i-1];
            assign s_prev = s_reg[i-1];
        end

        assign dbl      = {r_prev, 1'b0};
        assign ge       = dbl >= {1'b0, d_prev};
        assign rem_next = ge ? POS_W'(dbl - {1'b0, d_prev}) : POS_W'(dbl);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else
                v_reg[i] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= rem_next;
            d_reg[i]   <= d_prev;
            q_reg[i]   <= {q_prev[Q30-2:0], ge};
            s_reg[i]   <= s_prev;
        end
    end

    assign out_valid = v_reg[Q30-1];
    assign quo       = q_reg[Q30-1];
    assign out_side  = s_reg[Q30-1];

endmodule

>>> hw/rtl/ctt_angle.sv
// ============================================================================
// ctt_angle
// Fold the ratio to the first quarter, scale by pi and square it (Q30).
// ============================================================================
module ctt_angle
    import ctt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [Q30-1:0]  t,
    input  side_t           in_side,
    output logic            out_valid,
    output logic [31:0]     z,
    output side_t           out_side
);

    localparam logic [Q30-1:0] HALF = Q30'(1 << (Q30 - 1));

    logic           v_reg [0:4];
    side_t          s_reg [0:4];
    logic [Q30-1:0] u_reg;
    logic [61:0]    pr_reg;
    logic [30:0]    y_reg;
    logic [61:0]    sq_reg;
    logic [31:0]    z_reg;

    logic           flip_next;
    logic [Q30-1:0] u_next;
    logic [62:0]    y_sum;
    logic [62:0]    z_sum;
    side_t          s0_next;

    always_comb
    begin
        flip_next    = t > HALF;
        u_next       = flip_next ? Q30'((31'd1 << Q30) - {1'b0, t}) : t;
        s0_next      = in_side;
        s0_next.flip = flip_next;
        y_sum        = {1'b0, pr_reg} + 63'(HALF);
        z_sum        = {1'b0, sq_reg} + 63'(HALF);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < 5; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg[0] <= s0_next;
        for (int i = 1; i < 5; i++)
            s_reg[i] <= s_reg[i-1];
        u_reg  <= u_next;
        pr_reg <= 62'(u_reg) * 62'(PI_Q30);
        y_reg  <= y_sum[60:30];
        sq_reg <= 62'(y_reg) * 62'(y_reg);
        z_reg  <= z_sum[61:30];
    end

    assign out_valid = v_reg[4];
    assign z         = z_reg;
    assign out_side  = s_reg[4];

endmodule

>>> hw/rtl/ctt_hstep.sv
// ============================================================================
// ctt_hstep
// One Horner step: a_out = ONE - ((z * a) >> 30) / dvs, three stages.
// ============================================================================
module ctt_hstep
    import ctt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [31:0]         z,
    input  logic [30:0]         a,
    input  side_t               in_side,
    input  logic [31:0]         recip,
    input  logic [6:0]          dvs,
    output logic                out_valid,
    output logic [31:0]         z_out,
    output logic signed [32:0]  a_out,
    output side_t               out_side
);

    logic               v_reg [0:2];
    logic [31:0]        z_reg [0:2];
    side_t              s_reg [0:2];
    logic [31:0]        p1_reg;
    logic [31:0]        p2_reg;
    logic [31:0]        q0_reg;
    logic signed [32:0] a_reg;

    logic [62:0]        prod_next;
    logic [63:0]        qm_next;
    logic [31:0]        rem;
    logic [31:0]        q;
    logic signed [32:0] a_next;

    always_comb
    begin
        prod_next = 63'(z) * 63'(a);
        qm_next   = 64'(p1_reg) * 64'(recip);
        // reciprocal estimate is low by at most one
        rem       = p2_reg - 32'(q0_reg * 32'(dvs));
        q         = q0_reg + 32'(rem >= 32'(dvs));
        a_next    = $signed(33'(ONE_Q30)) - $signed({1'b0, q});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < 3; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg[0] <= z;
        s_reg[0] <= in_side;
        for (int i = 1; i < 3; i++)
        begin
            z_reg[i] <= z_reg[i-1];
            s_reg[i] <= s_reg[i-1];
        end
        p1_reg <= prod_next[61:30];
        p2_reg <= p1_reg;
        q0_reg <= qm_next[63:32];
        a_reg  <= a_next;
    end

    assign out_valid = v_reg[2];
    assign z_out     = z_reg[2];
    assign a_out     = a_reg;
    assign out_side  = s_reg[2];

endmodule

>>> hw/rtl/ctt_out.sv
// ============================================================================
// ctt_out
// Form the taper factor, scale the magnitude, round and select the result.
// ============================================================================
module ctt_out
    import ctt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [32:0]  c,
    input  side_t               in_side,
    output logic                done,
    output logic [VAL_W-1:0]    tapered_value
);

    localparam int SH = Q30 - FRAC_BITS;

    logic               v_reg [0:2];
    side_t              s_reg [0:1];
    logic [F_W-1:0]     f_reg;
    logic [VAL_W-1:0]   mag_reg;
    logic [VAL_W+F_W-1:0] prod_reg;
    logic [VAL_W-1:0]   out_reg;

    logic [30:0]        cc;
    logic [31:0]        gsum;
    logic [30:0]        g;
    logic [31:0]        fsum;
    logic [VAL_W+F_W-1:0] rsum;
    logic [VAL_W-1:0]   r;
    logic [VAL_W-1:0]   out_next;

    always_comb
    begin
        if (c < 0)
            cc = '0;
        else if (c > $signed(33'(ONE_Q30)))
            cc = ONE_Q30;
        else
            cc = c[30:0];
        gsum = 32'(ONE_Q30) + 32'(cc);
        g    = gsum[31:1];
        if (in_side.flip)
            g = ONE_Q30 - g;
        fsum = 32'(g) + 32'(1 << (SH - 1));
        rsum = prod_reg + (VAL_W+F_W)'(1 << (FRAC_BITS - 1));
        r    = rsum[FRAC_BITS +: VAL_W];
        case (s_reg[1].mode)
            MODE_ZERO:  out_next = '0;
            MODE_TAPER: out_next = s_reg[1].raw[VAL_W-1] ? VAL_W'(-r) : r;
            default:    out_next = s_reg[1].raw;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg[0] <= in_side;
        s_reg[1] <= s_reg[0];
        f_reg    <= fsum[SH +: F_W];
        mag_reg  <= in_side.raw[VAL_W-1] ? VAL_W'(-in_side.raw) : in_side.raw;
        prod_reg <= (VAL_W+F_W)'(mag_reg) * (VAL_W+F_W)'(f_reg);
        out_reg  <= out_next;
    end

    assign done          = v_reg[2];
    assign tapered_value = out_reg;

endmodule

>>> hw/rtl/cosine_taper_truncation_top.sv
// ============================================================================
// cosine_taper_truncation_top
// Raised-cosine taper and truncation of tabulated curve samples.
// ============================================================================
// One sample is taken in every clock cycle (busy stays low) and its result
// appears on tapered_value with done high after it has passed one input
// stage, a 30-stage bit-per-stage divider forming the normalized offset, five
// angle stages, five three-stage Horner steps for the cosine and three output
// stages. Results cannot be held off, so the receiver must take done as it
// comes. Write r_min and r_max only while no sample is in flight.
module cosine_taper_truncation_top
    import ctt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [POS_W-1:0]    position,
    input  logic [VAL_W-1:0]    sample_value,
    output logic                done,
    output logic [VAL_W-1:0]    tapered_value,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [POS_W-1:0]    cfg_data
);

    logic [POS_W-1:0] r_min_reg;
    logic [POS_W-1:0] r_max_reg;
    logic             v0_reg;
    logic [POS_W-1:0] off_reg;
    logic [POS_W-1:0] d_reg;
    side_t            s0_reg;
    side_t            s0_next;

    logic             div_valid;
    logic [Q30-1:0]   div_quo;
    side_t            div_side;
    logic             ang_valid;
    logic [31:0]      ang_z;
    side_t            ang_side;

    logic               hs_valid [0:HSTEPS];
    logic [31:0]        hs_z     [0:HSTEPS];
    logic signed [32:0] hs_a     [0:HSTEPS];
    side_t              hs_side  [0:HSTEPS];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_min_reg <= POS_W'(851968);
            r_max_reg <= POS_W'(983040);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_R_MIN: r_min_reg <= cfg_data;
                REG_R_MAX: r_max_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // r_max test first, so an empty region never reaches the taper
    always_comb
    begin
        s0_next.raw  = sample_value;
        s0_next.flip = 1'b0;
        if (position >= r_max_reg)
            s0_next.mode = MODE_ZERO;
        else if (position > r_min_reg)
            s0_next.mode = MODE_TAPER;
        else
            s0_next.mode = MODE_PASS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        off_reg <= position - r_min_reg;
        d_reg   <= r_max_reg - r_min_reg;
        s0_reg  <= s0_next;
    end

    ctt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .off       (off_reg),
        .d         (d_reg),
        .in_side   (s0_reg),
        .out_valid (div_valid),
        .quo       (div_quo),
        .out_side  (div_side)
    );

    ctt_angle u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .t         (div_quo),
        .in_side   (div_side),
        .out_valid (ang_valid),
        .z         (ang_z),
        .out_side  (ang_side)
    );

    assign hs_valid[0] = ang_valid;
    assign hs_z[0]     = ang_z;
    assign hs_a[0]     = $signed(33'(ONE_Q30));
    assign hs_side[0]  = ang_side;

    for (genvar i = 0; i < HSTEPS; i++)
    begin : g_horner
        ctt_hstep u_hstep (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (hs_valid[i]),
            .z         (hs_z[i]),
            .a         (hs_a[i][30:0]),
            .in_side   (hs_side[i]),
            .recip     (HORNER_RECIP[i]),
            .dvs       (HORNER_DIV[i]),
            .out_valid (hs_valid[i+1]),
            .z_out     (hs_z[i+1]),
            .a_out     (hs_a[i+1]),
            .out_side  (hs_side[i+1])
        );
    end

    ctt_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (hs_valid[HSTEPS]),
        .c             (hs_a[HSTEPS]),
        .in_side       (hs_side[HSTEPS]),
        .done          (done),
        .tapered_value (tapered_value)
    );

endmodule
